/* rtl/core/bvt_pkg.sv */
// Shared constants and types for the bounded value table.
`default_nettype none
package bvt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int OUT_CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd5;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_CNT_W-1:0] match_count;
        logic [OUT_CNT_W-1:0] fill_level;
        logic                 is_full;
        logic                 is_empty;
        logic                 rejected;
    } result_t;

endpackage
`default_nettype wire

/* rtl/core/bvt_store.sv */
// Entry storage: one write port, one registered read port.
`default_nettype none
module bvt_store (
    input  wire logic                        clk,
    input  wire bvt_pkg::wr_req_t            wr,
    input  wire logic [bvt_pkg::IDX_W-1:0]   raddr,
    output logic      [bvt_pkg::DATA_W-1:0]  rdata
);

    logic [bvt_pkg::DATA_W-1:0] mem [bvt_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/bvt_seq.sv */
// Sequencer: scans the filled range through one comparator, counts and compacts.
`default_nettype none
module bvt_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [bvt_pkg::CMD_W-1:0]     req_cmd,
    input  wire logic [bvt_pkg::DATA_W-1:0]    req_value,
    input  wire logic                          slot_free,
    output logic                               res_valid,
    output bvt_pkg::result_t                   res,
    output bvt_pkg::wr_req_t                   wr,
    output logic      [bvt_pkg::IDX_W-1:0]     raddr,
    input  wire logic [bvt_pkg::DATA_W-1:0]    rdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [bvt_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [bvt_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [bvt_pkg::CNT_W-1:0]    rd_reg, rd_next;
    logic [bvt_pkg::CNT_W-1:0]    wr_reg, wr_next;
    logic [bvt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [bvt_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic                         pend_reg, pend_next;
    logic                         first_done_reg, first_done_next;
    logic                         rej_reg, rej_next;

    logic hit;
    logic drop;
    logic is_del;
    logic scan_done;

    assign is_del    = (cmd_reg == bvt_pkg::CMD_DEL_FIRST) || (cmd_reg == bvt_pkg::CMD_DEL_ALL);
    assign hit       = pend_reg && (rdata == value_reg);
    assign drop      = hit && ((cmd_reg == bvt_pkg::CMD_DEL_ALL) ||
                               ((cmd_reg == bvt_pkg::CMD_DEL_FIRST) && !first_done_reg));
    assign scan_done = (rd_reg >= fill_reg) && !pend_reg;
    assign raddr     = rd_reg[bvt_pkg::IDX_W-1:0];
    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH) && slot_free;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        pend_next       = 1'b0;
        first_done_next = first_done_reg;
        rej_next        = rej_reg;
        wr.en           = 1'b0;
        wr.addr         = wr_reg[bvt_pkg::IDX_W-1:0];
        wr.data         = rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req_cmd;
                    value_next      = req_value;
                    rd_next         = '0;
                    wr_next         = '0;
                    cnt_next        = '0;
                    first_done_next = 1'b0;
                    rej_next        = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read for index rd issues now, its data is compared next cycle
                if (rd_reg < fill_reg)
                begin
                    rd_next   = bvt_pkg::CNT_W'(rd_reg + 1'b1);
                    pend_next = 1'b1;
                end
                if (hit)
                begin
                    cnt_next = bvt_pkg::CNT_W'(cnt_reg + 1'b1);
                    if (cmd_reg == bvt_pkg::CMD_DEL_FIRST)
                    begin
                        first_done_next = 1'b1;
                    end
                end
                if (pend_reg && !drop)
                begin
                    // survivor moves down to the write pointer (never past the read side)
                    wr.en   = is_del;
                    wr_next = bvt_pkg::CNT_W'(wr_reg + 1'b1);
                end
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                    case (cmd_reg)
                        bvt_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        bvt_pkg::CMD_APPEND:
                        begin
                            if (fill_reg >= bvt_pkg::CNT_W'(bvt_pkg::CAPACITY))
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                wr.en     = 1'b1;
                                wr.addr   = fill_reg[bvt_pkg::IDX_W-1:0];
                                wr.data   = value_reg;
                                fill_next = bvt_pkg::CNT_W'(fill_reg + 1'b1);
                            end
                        end
                        bvt_pkg::CMD_DEL_FIRST,
                        bvt_pkg::CMD_DEL_ALL:
                        begin
                            fill_next = wr_reg;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.found       = (cnt_reg != '0);
        res.match_count = bvt_pkg::OUT_CNT_W'(cnt_reg);
        res.fill_level  = bvt_pkg::OUT_CNT_W'(fill_reg);
        res.is_full     = (fill_reg == bvt_pkg::CNT_W'(bvt_pkg::CAPACITY));
        res.is_empty    = (fill_reg == '0);
        res.rejected    = rej_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_reg         <= '0;
            wr_reg         <= '0;
            cnt_reg        <= '0;
            fill_reg       <= '0;
            pend_reg       <= 1'b0;
            first_done_reg <= 1'b0;
            rej_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
            pend_reg       <= pend_next;
            first_done_reg <= first_done_next;
            rej_reg        <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

/* rtl/core/bounded_value_table_top.sv */
// Bounded value table: a packed table of up to CAPACITY signed 32-bit values
// (clear, append, delete first, delete all, search, count). Every request walks
// the filled range through one shared comparator, one entry per cycle off the
// entry memory's single read port, before the result is registered at the output.
// One request is handled at a time; a finished result sits in the output register
// while the next request is taken. No clearing pass is needed after reset.
`default_nettype none
module bounded_value_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic signed [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [4:0]       match_count,
    output logic [4:0]       fill_level,
    output logic             is_full,
    output logic             is_empty,
    output logic             rejected
);

    bvt_pkg::wr_req_t                 wr;
    bvt_pkg::result_t                 res;
    logic [bvt_pkg::IDX_W-1:0]        raddr;
    logic [bvt_pkg::DATA_W-1:0]       rdata;
    logic                             res_valid;
    logic                             slot_free;
    logic                             out_valid_reg, out_valid_next;
    bvt_pkg::result_t                 out_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    bvt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_stall (in_stall),
        .req_cmd   (command),
        .req_value (value),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .wr        (wr),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    bvt_store u_store (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_reg.found;
    assign match_count = out_reg.match_count;
    assign fill_level  = out_reg.fill_level;
    assign is_full     = out_reg.is_full;
    assign is_empty    = out_reg.is_empty;
    assign rejected    = out_reg.rejected;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but sequencer not busy");

    a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found == (match_count != 5'd0)))
        else $error("found disagrees with match count");

    a_reject_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> is_full)
        else $error("append rejected while table not full");

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_full && is_empty))
        else $error("table reported both full and empty");

endmodule
`default_nettype wire

/* dv/bounded_value_table_top_tb.sv */
// Self-checking testbench for the bounded value table with shadow table prediction.
`default_nettype none
module bounded_value_table_top_tb;

    localparam logic [bvt_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [bvt_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;
    localparam logic signed [bvt_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [bvt_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [bvt_pkg::CMD_W-1:0]         command = bvt_pkg::CMD_CLEAR;
    logic signed [bvt_pkg::DATA_W-1:0] value = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              found;
    logic [4:0]                        match_count;
    logic [4:0]                        fill_level;
    logic                              is_full;
    logic                              is_empty;
    logic                              rejected;

    // shadow copy of the table contents
    logic signed [bvt_pkg::DATA_W-1:0] table_vals [bvt_pkg::CAPACITY];
    int                                table_fill = 0;

    bvt_pkg::result_t                  pending_results [$];
    logic signed [bvt_pkg::DATA_W-1:0] value_pool [8];
    int                                idle_pct = 0;
    int                                error_count = 0;
    int                                cmd_seen [8];
    int                                reject_total = 0;
    int                                full_total = 0;
    int                                results_checked = 0;

    bounded_value_table_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_count (match_count),
        .fill_level  (fill_level),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .rejected    (rejected)
    );

    always #5 clk = ~clk;

    // Applies one command to the shadow table and returns what the block should report.
    function automatic bvt_pkg::result_t apply_table_command(
        input logic [bvt_pkg::CMD_W-1:0] cmd,
        input logic signed [bvt_pkg::DATA_W-1:0] val);
        bvt_pkg::result_t res;
        int      hits;
        int      first_hit;
        int      keep;
        bit      refused;
        hits = 0;
        first_hit = -1;
        keep = 0;
        refused = 1'b0;
        // found and match_count always describe the table before the command
        for (int i = 0; i < table_fill; i++)
        begin
            if (table_vals[i] == val)
            begin
                hits++;
                if (first_hit < 0)
                    first_hit = i;
            end
        end
        case (cmd)
            bvt_pkg::CMD_CLEAR:
                table_fill = 0;
            bvt_pkg::CMD_APPEND:
                if (table_fill >= bvt_pkg::CAPACITY)
                    refused = 1'b1;
                else
                begin
                    table_vals[table_fill] = val;
                    table_fill++;
                end
            bvt_pkg::CMD_DEL_FIRST:
                if (first_hit >= 0)
                begin
                    for (int k = first_hit; k < table_fill - 1; k++)
                        table_vals[k] = table_vals[k + 1];
                    table_fill--;
                end
            bvt_pkg::CMD_DEL_ALL:
            begin
                for (int i = 0; i < table_fill; i++)
                begin
                    if (table_vals[i] != val)
                    begin
                        table_vals[keep] = table_vals[i];
                        keep++;
                    end
                end
                table_fill = keep;
            end
            default:
                ;
        endcase
        res.found       = (hits != 0);
        res.match_count = hits[4:0];
        res.fill_level  = table_fill[4:0];
        res.is_full     = (table_fill == bvt_pkg::CAPACITY);
        res.is_empty    = (table_fill == 0);
        res.rejected    = refused;
        return res;
    endfunction

    // Holds the request until accepted; stall is sampled mid-cycle, ahead of the deciding edge.
    task automatic send_request(input logic [bvt_pkg::CMD_W-1:0] cmd,
                                input logic signed [bvt_pkg::DATA_W-1:0] val);
        bit               stalled;
        bvt_pkg::result_t exp;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        exp = apply_table_command(cmd, val);
        pending_results.push_back(exp);
        cmd_seen[cmd]++;
        if (exp.rejected)
            reject_total++;
        if (exp.is_full)
            full_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            error_count++;
        end
    endtask

    // Results are taken at the edge that follows this sample point.
    always @(negedge clk)
    begin
        bvt_pkg::result_t exp;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                results_checked++;
                check_field("found", exp.found, found);
                check_field("match_count", exp.match_count, match_count);
                check_field("fill_level", exp.fill_level, fill_level);
                check_field("is_full", exp.is_full, is_full);
                check_field("is_empty", exp.is_empty, is_empty);
                check_field("rejected", exp.rejected, rejected);
            end
        end
    end

    // Receiver back-pressure in short bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [bvt_pkg::CMD_W-1:0] pick_command(input int append_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < append_pct)
            return bvt_pkg::CMD_APPEND;
        r = $urandom_range(0, 99);
        if (r < 3)
            return bvt_pkg::CMD_CLEAR;
        if (r < 28)
            return bvt_pkg::CMD_DEL_FIRST;
        if (r < 45)
            return bvt_pkg::CMD_DEL_ALL;
        if (r < 70)
            return bvt_pkg::CMD_SEARCH;
        if (r < 94)
            return bvt_pkg::CMD_COUNT;
        if (r < 97)
            return CMD_SPARE6;
        return CMD_SPARE7;
    endfunction

    // Mostly values that are or could be in the table, so matches and duplicates are common.
    function automatic logic signed [bvt_pkg::DATA_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && table_fill != 0)
            return table_vals[$urandom_range(0, table_fill - 1)];
        if (r < 85)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic test_empty_table();
        send_request(bvt_pkg::CMD_CLEAR, 0);
        send_request(bvt_pkg::CMD_SEARCH, -1);
        send_request(bvt_pkg::CMD_DEL_ALL, 5);
    endtask

    task automatic test_fill_to_capacity();
        logic signed [bvt_pkg::DATA_W-1:0] fill_vals [16];
        fill_vals = '{VAL_MIN, VAL_MAX, 0, -1, 10, -999, 10, 32'sh5555_5555,
                      32'shaaaa_aaaa, 10, VAL_MIN, 1, -999, 10, 32'sh0f0f_0f0f, VAL_MAX};
        foreach (fill_vals[i])
            send_request(bvt_pkg::CMD_APPEND, fill_vals[i]);
        // table is full now, so this one is refused
        send_request(bvt_pkg::CMD_APPEND, 7);
    endtask

    task automatic test_delete_and_query();
        send_request(bvt_pkg::CMD_COUNT, 10);
        send_request(bvt_pkg::CMD_DEL_FIRST, 10);
        send_request(bvt_pkg::CMD_DEL_ALL, 10);
        send_request(bvt_pkg::CMD_DEL_FIRST, 12345);
        send_request(CMD_SPARE6, VAL_MIN);
        send_request(CMD_SPARE7, -999);
        send_request(bvt_pkg::CMD_CLEAR, VAL_MAX);
    endtask

    task automatic test_random_traffic();
        int seg_idle [8];
        int seg_append [8];
        seg_idle   = '{25, 0, 50, 25, 10, 50, 25, 0};
        seg_append = '{70, 40, 85, 55, 30, 75, 60, 65};
        for (int s = 0; s < 8; s++)
        begin
            idle_pct = seg_idle[s];
            value_pool = '{VAL_MIN, VAL_MAX, 0, -1, 10, -999, $urandom, $urandom};
            for (int n = 0; n < 100; n++)
                send_request(pick_command(seg_append[s]), pick_operand());
        end
    endtask

    initial
    begin
        int drain_wait;
        drain_wait = 0;
        foreach (table_vals[i])
            table_vals[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_fill_to_capacity();
        test_delete_and_query();
        test_random_traffic();
        in_valid <= 1'b0;
        idle_pct = 0;
        while (pending_results.size() != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        repeat (bvt_pkg::CAPACITY + 8) @(posedge clk);
        $display("checked %0d results: clear %0d, append %0d, del-first %0d, del-all %0d,",
                 results_checked, cmd_seen[bvt_pkg::CMD_CLEAR], cmd_seen[bvt_pkg::CMD_APPEND],
                 cmd_seen[bvt_pkg::CMD_DEL_FIRST], cmd_seen[bvt_pkg::CMD_DEL_ALL]);
        $display("search %0d, count %0d, spare codes %0d; %0d refused appends, %0d full results",
                 cmd_seen[bvt_pkg::CMD_SEARCH], cmd_seen[bvt_pkg::CMD_COUNT],
                 cmd_seen[CMD_SPARE6] + cmd_seen[CMD_SPARE7], reject_total, full_total);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
